/* hdl/m2h_pkg.sv */
// m2h_pkg: shared types and constants of the murmur2 hash engine
// used by the front, queue and back modules and the top level; no dependencies
package m2h_pkg;

	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int unsigned KEY_SHIFT   = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;

	localparam int unsigned TDATA_W = 104;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_EMPTY,
		KIND_PART,
		KIND_FULL
	} kind_t;

	// classified word as it travels from front to back
	typedef struct packed {
		logic        first;
		logic [31:0] init_h;
		logic [31:0] word;
		kind_t       kind;
		logic        last;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MK1,
		ST_MK2,
		ST_MH,
		ST_MP,
		ST_AV,
		ST_FIN
	} back_state_t;

	typedef struct packed {
		logic busy;
		logic emitting;
	} back_status_t;

endpackage

/* hdl/m2h_front.sv */
// m2h_front: accepts stream words, clamps the byte count, masks stray bytes
// and precomputes seed xor length; depends on m2h_pkg
module m2h_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [m2h_pkg::TDATA_W-1:0]   s_tdata,
	input  logic                          s_tuser,
	input  logic                          s_tlast,
	output logic                          push,
	output m2h_pkg::item_t                push_item,
	input  logic                          push_ready
);
	import m2h_pkg::*;

	logic  fv_q;
	item_t item_q;
	item_t item_d;
	logic [31:0] seed;
	logic [31:0] len;
	logic [31:0] word;
	logic [2:0]  count;

	assign seed  = s_tdata[31:0];
	assign len   = s_tdata[63:32];
	assign word  = s_tdata[95:64];
	assign count = s_tdata[98:96];

	always_comb begin
		item_d.first  = s_tuser;
		item_d.init_h = seed ^ len;
		item_d.last   = s_tlast;
		// counts of four and above are a full word
		case (count)
			3'd0: begin
				item_d.kind = KIND_EMPTY;
				item_d.word = '0;
			end
			3'd1: begin
				item_d.kind = KIND_PART;
				item_d.word = {24'h0, word[7:0]};
			end
			3'd2: begin
				item_d.kind = KIND_PART;
				item_d.word = {16'h0, word[15:0]};
			end
			3'd3: begin
				item_d.kind = KIND_PART;
				item_d.word = {8'h0, word[23:0]};
			end
			default: begin
				item_d.kind = KIND_FULL;
				item_d.word = word;
			end
		endcase
	end

	assign s_tready  = !fv_q || push_ready;
	assign push      = fv_q;
	assign push_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= 1'b0;
		end else if (s_tready) begin
			fv_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_q <= item_d;
		end
	end

endmodule

/* hdl/m2h_queue.sv */
// m2h_queue: short register fifo between front and back
// depth from m2h_pkg::QUEUE_DEPTH; depends on m2h_pkg
module m2h_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  m2h_pkg::item_t push_item,
	output logic           push_ready,
	input  logic           pop,
	output m2h_pkg::item_t pop_item,
	output logic           pop_valid
);
	import m2h_pkg::*;

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* hdl/m2h_back.sv */
// m2h_back: sequencer that mixes each word into the running hash with one
// shared constant multiplier and emits the avalanched hash; depends on m2h_pkg
module m2h_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	input  m2h_pkg::item_t        pop_item,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,
	output m2h_pkg::back_status_t status
);
	import m2h_pkg::*;

	back_state_t state_q;
	back_state_t state_d;
	logic [31:0] h_q;
	logic [31:0] k_q;
	logic [31:0] a_q;
	logic        last_q;
	logic [31:0] out_q;
	logic        out_valid_q;
	logic [31:0] mul_a;
	logic [31:0] prod;
	logic        load_out;
	logic [31:0] fin;

	assign prod = mul_a * MIX_MUL;
	assign fin  = a_q ^ (a_q >> FIN_SHIFT_B);

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		mul_a    = h_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					pop = 1'b1;
					unique case (pop_item.kind)
						KIND_FULL:  state_d = ST_MK1;
						KIND_PART:  state_d = ST_MP;
						default:    state_d = pop_item.last ? ST_AV : ST_IDLE;
					endcase
				end
			end
			ST_MK1: begin
				mul_a   = k_q;
				state_d = ST_MK2;
			end
			ST_MK2: begin
				mul_a   = k_q ^ (k_q >> KEY_SHIFT);
				state_d = ST_MH;
			end
			ST_MH: begin
				mul_a   = h_q;
				state_d = last_q ? ST_AV : ST_IDLE;
			end
			ST_MP: begin
				mul_a   = h_q ^ k_q;
				state_d = last_q ? ST_AV : ST_IDLE;
			end
			ST_AV: begin
				mul_a   = h_q ^ (h_q >> FIN_SHIFT_A);
				state_d = ST_FIN;
			end
			ST_FIN: begin
				// wait here while the previous hash is still unclaimed
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// running hash keeps the value before the avalanche
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && pop_item.first) begin
						h_q <= pop_item.init_h;
					end
				end
				ST_MH:   h_q <= prod ^ k_q;
				ST_MP:   h_q <= prod;
				default: h_q <= h_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					k_q    <= pop_item.word;
					last_q <= pop_item.last;
				end
			end
			ST_MK1, ST_MK2: k_q <= prod;
			ST_AV:          a_q <= prod;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= fin;
		end
	end

	assign m_tvalid        = out_valid_q;
	assign m_tdata         = out_q;
	assign status.busy     = state_q != ST_IDLE;
	assign status.emitting = load_out;

endmodule

/* hdl/murmur2_hash32_engine_core.sv */
// murmur2_hash32_engine_core: streaming 32-bit murmur2 hash, front classifier,
// two-word queue and multiply sequencer; depends on m2h_pkg and the m2h modules
// path: each word passes the front register and the queue before the sequencer
// pops it; a full word then steps through MK1, MK2 and MH, a partial word through MP,
// an empty one through neither, and a last word adds AV and FIN for the avalanche
// rate: the shared multiplier makes the sequencer finish each word before it pops the next
// reset: arst_n clears the handshakes, the queue and the running hash to zero
module murmur2_hash32_engine_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// seed_value, message_length, data_word, byte_count, zero pad
	input  logic [m2h_pkg::TDATA_W-1:0] s_tdata,
	// first_word
	input  logic                        s_tuser,
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// hash_value
	output logic [31:0]                 m_tdata
);
	import m2h_pkg::*;

	logic         push;
	item_t        push_item;
	logic         push_ready;
	logic         pop;
	item_t        pop_item;
	logic         pop_valid;
	back_status_t status;

	m2h_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	m2h_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid)
	);

	m2h_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.status    (status)
	);

`ifndef NO_ASSERTIONS
	// sequencer only takes a word the queue offers, and only when idle
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (pop_valid && !status.busy))
		else $error("pop without a queued word or while busy");

	// a new hash appears only after the sequencer finished one
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(status.emitting))
		else $error("hash shown without an emit step");

	// an emit never overwrites an unclaimed hash
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		status.emitting |-> (!m_tvalid || m_tready))
		else $error("hash overwritten while stalled");
`endif

endmodule
